// ----- rtl/core/pscb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscb_pkg
// Shared constants, codes and control types of the packed sprite column blit.
// ----------------------------------------------------------------------------
package pscb_pkg;

    localparam int DEF_SCREEN_WIDTH  = 120;
    localparam int DEF_SCREEN_HEIGHT = 60;

    localparam int ADDR_IN_W = 11;
    localparam int CMP_W     = 12;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] STATUS_DRAWN   = 2'd0;
    localparam logic [1:0] STATUS_CLIPPED = 2'd1;
    localparam logic [1:0] STATUS_READ    = 2'd2;

    localparam logic [7:0] KEEP_LEFT  [4] = '{8'h00, 8'hc0, 8'hf0, 8'hfc};
    localparam logic [7:0] KEEP_RIGHT [4] = '{8'h00, 8'h3f, 8'h0f, 8'h03};

    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic rd_sel_b;
        logic wr_a;
        logic wr_b;
        logic load_out;
    } pscb_cmd_t;

    typedef struct packed {
        logic clear_last;
    } pscb_sts_t;

endpackage

// ----- rtl/core/pscb_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscb_req_if
// Request channel: draw a sprite row or read a frame byte.
// ----------------------------------------------------------------------------
interface pscb_req_if;
    import pscb_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   operation;
    logic signed [7:0]      pos_x;
    logic signed [7:0]      row_y;
    logic [7:0]             sprite_byte;
    logic [ADDR_IN_W-1:0]   read_address;

    modport source (
        output valid, operation, pos_x, row_y, sprite_byte, read_address,
        input  ready
    );

    modport sink (
        input  valid, operation, pos_x, row_y, sprite_byte, read_address,
        output ready
    );
endinterface

// ----- rtl/core/pscb_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscb_rsp_if
// Response channel: frame byte and status of one request.
// ----------------------------------------------------------------------------
interface pscb_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [1:0] status;

    modport source (
        output valid, read_data, status,
        input  ready
    );

    modport sink (
        input  valid, read_data, status,
        output ready
    );
endinterface

// ----- rtl/core/packed_sprite_column_blit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_sprite_column_blit
// 2-bit-per-pixel packed frame store with sprite row draw and byte read.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request: operation 0 draws the four pixels of sprite_byte
//   at (pos_x, row_y), clipped to the screen; operation 1 reads frame byte
//   read_address. rsp returns one result per request, in order: read_data
//   (frame byte for reads, zero for draws) and status (drawn, clipped, read).
//   A request is taken on req.valid && req.ready; its result is presented
//   via an output register loaded after its steps, held until rsp.ready.
//   Each request walks read A, read B / write A, write B on a memory with
//   one write and one read port; no new request is taken until it is done.
//   While a result waits on a stalled receiver the next request can be taken
//   and is worked up to its own output step, where it waits for the slot.
//   After rst_n is released the frame store is zeroed one byte per cycle,
//   all ROW_BYTES * SCREEN_HEIGHT bytes (1800 at the default size), with
//   req.ready low until that is done.
// ----------------------------------------------------------------------------
module packed_sprite_column_blit #(
    parameter int SCREEN_WIDTH  = pscb_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = pscb_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic       clk,
    input  logic       rst_n,
    pscb_req_if.sink   req,
    pscb_rsp_if.source rsp
);
    import pscb_pkg::*;

    pscb_cmd_t cmd;
    pscb_sts_t sts;

    pscb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pscb_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .operation    (req.operation),
        .pos_x        (req.pos_x),
        .row_y        (req.row_y),
        .sprite_byte  (req.sprite_byte),
        .read_address (req.read_address),
        .read_data    (rsp.read_data),
        .status       (rsp.status)
    );
endmodule

// ----- rtl/core/pscb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscb_ctrl
// Sequencer: clearing pass, request intake, read-modify-write steps, output.
// ----------------------------------------------------------------------------
module pscb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  pscb_pkg::pscb_sts_t sts,
    output pscb_pkg::pscb_cmd_t cmd
);
    import pscb_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_RD_A  = 6'b000100,
        S_RD_B  = 6'b001000,
        S_WR_B  = 6'b010000,
        S_HOLD  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_RD_A;
                end
            end
            S_RD_A:
            begin
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                cmd.rd_sel_b = 1'b1;
                cmd.wr_a     = 1'b1;
                state_next   = S_WR_B;
            end
            S_WR_B:
            begin
                cmd.wr_b = 1'b1;
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// ----- rtl/core/pscb_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscb_datapath
// Frame store, address and mask setup, byte merge and result register.
// ----------------------------------------------------------------------------
module pscb_datapath #(
    parameter int SCREEN_WIDTH  = pscb_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = pscb_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pscb_pkg::pscb_cmd_t            cmd,
    output pscb_pkg::pscb_sts_t            sts,
    input  logic                           operation,
    input  logic signed [7:0]              pos_x,
    input  logic signed [7:0]              row_y,
    input  logic [7:0]                     sprite_byte,
    input  logic [pscb_pkg::ADDR_IN_W-1:0] read_address,
    output logic [7:0]                     read_data,
    output logic [1:0]                     status
);
    import pscb_pkg::*;

    localparam int ROW_BYTES   = SCREEN_WIDTH / 4;
    localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;
    localparam int AW          = $clog2(STORE_BYTES);

    localparam logic signed [8:0] X_MIN   = -9'sd3;
    localparam logic signed [8:0] X_LIM   = 9'(SCREEN_WIDTH);
    localparam logic signed [8:0] X_EDGE  = 9'(SCREEN_WIDTH - 4);

    logic [7:0]     mem [STORE_BYTES];
    logic [7:0]     rd_data_reg;
    logic [AW-1:0]  rd_addr;
    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    logic [7:0]     mem_wd;

    logic [AW-1:0]  clr_cnt_reg;
    logic [AW-1:0]  clr_cnt_next;

    logic signed [8:0] x9;
    logic           neg;
    logic [1:0]     sh;
    logic [4:0]     col_a;
    logic [5:0]     col_b;
    logic           row_ok;
    logic           x_ok;
    logic           right_edge;
    logic           clipped;
    logic           is_draw;
    logic           en_a;
    logic           en_b;
    logic [15:0]    spread;
    logic [AW-1:0]  base;

    logic           op_reg;
    logic           in_range_reg;
    logic           clipped_reg;
    logic           en_a_reg;
    logic           en_b_reg;
    logic [AW-1:0]  addr_a_reg;
    logic [AW-1:0]  addr_b_reg;
    logic [7:0]     keep_a_reg;
    logic [7:0]     val_a_reg;
    logic [7:0]     keep_b_reg;
    logic [7:0]     val_b_reg;
    logic [7:0]     rdval_reg;
    logic [7:0]     out_data_reg;
    logic [1:0]     out_status_reg;

    assign x9         = 9'(pos_x);
    assign neg        = pos_x[7];
    assign sh         = pos_x[1:0];
    assign col_a      = pos_x[6:2];
    assign col_b      = neg ? 6'd0 : 6'(col_a) + 6'd1;
    assign row_ok     = !row_y[7] && (row_y[6:0] < 7'(SCREEN_HEIGHT));
    assign x_ok       = (x9 >= X_MIN) && (x9 < X_LIM);
    assign right_edge = (x9 > X_EDGE);
    assign clipped    = !row_ok || !x_ok || (right_edge && sh == 2'd0);
    assign is_draw    = (operation == OP_DRAW) && !clipped;
    assign en_a       = is_draw && !neg && (col_a < 5'(ROW_BYTES));
    assign en_b       = is_draw && (sh != 2'd0) && (neg || !right_edge)
                        && (col_b < 6'(ROW_BYTES));
    assign spread     = {sprite_byte, 8'h00} >> {sh, 1'b0};
    assign base       = AW'(32'(row_y[6:0]) * ROW_BYTES);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= operation;
            in_range_reg <= (CMP_W'(read_address) < CMP_W'(STORE_BYTES));
            clipped_reg  <= clipped;
            en_a_reg     <= en_a;
            en_b_reg     <= en_b;
            addr_a_reg   <= (operation == OP_READ) ? AW'(read_address)
                                                   : base + AW'(col_a);
            addr_b_reg   <= base + AW'(col_b);
            keep_a_reg   <= (sh == 2'd0) ? 8'h00 : KEEP_LEFT[sh];
            val_a_reg    <= spread[15:8];
            keep_b_reg   <= KEEP_RIGHT[sh];
            val_b_reg    <= spread[7:0];
        end
        if (cmd.wr_a)
        begin
            rdval_reg <= rd_data_reg;
        end
        if (cmd.load_out)
        begin
            if (op_reg == OP_READ)
            begin
                out_data_reg   <= in_range_reg ? rdval_reg : 8'h00;
                out_status_reg <= STATUS_READ;
            end
            else
            begin
                out_data_reg   <= 8'h00;
                out_status_reg <= clipped_reg ? STATUS_CLIPPED : STATUS_DRAWN;
            end
        end
    end

    // clearing pass counter
    assign clr_cnt_next   = clr_cnt_reg + AW'(1);
    assign sts.clear_last = (clr_cnt_reg == AW'(STORE_BYTES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_wr && !sts.clear_last)
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // single write port, single registered read port
    assign rd_addr = cmd.rd_sel_b ? addr_b_reg : addr_a_reg;

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = clr_cnt_reg;
        mem_wd = 8'h00;
        if (cmd.clear_wr)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.wr_a)
        begin
            mem_we = en_a_reg;
            mem_wa = addr_a_reg;
            mem_wd = (rd_data_reg & keep_a_reg) | val_a_reg;
        end
        else if (cmd.wr_b)
        begin
            mem_we = en_b_reg;
            mem_wa = addr_b_reg;
            mem_wd = (rd_data_reg & keep_b_reg) | val_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign read_data = out_data_reg;
    assign status    = out_status_reg;
endmodule

// ----- tb/tb_packed_sprite_column_blit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packed_sprite_column_blit
// Self-checking testbench for the packed 2bpp sprite row blitter.
// Draws and reads go through the request channel. A local copy of the frame
// store predicts every response, and responses are checked in order. The run
// has directed edge, clip and range cases, then random traffic with idle
// cycles on both sides, a long response stall and a full drain pause.
// ----------------------------------------------------------------------------
module tb_packed_sprite_column_blit;
    import pscb_pkg::*;

    localparam int SCREEN_W     = DEF_SCREEN_WIDTH;
    localparam int SCREEN_H     = DEF_SCREEN_HEIGHT;
    localparam int ROW_BYTES    = SCREEN_W / 4;
    localparam int STORE_BYTES  = ROW_BYTES * SCREEN_H;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct {
        logic                 operation;
        logic [7:0]           pos_x;
        logic [7:0]           row_y;
        logic [7:0]           sprite_byte;
        logic [ADDR_IN_W-1:0] read_address;
    } blit_req_t;

    typedef struct {
        logic [7:0] read_data;
        logic [1:0] status;
    } blit_result_t;

    logic clk;
    logic rst_n;

    pscb_req_if req ();
    pscb_rsp_if rsp ();

    packed_sprite_column_blit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    logic [7:0]   frame_mem [STORE_BYTES];
    blit_result_t pending_results [$];
    int           mismatches;
    int           cycle_count;
    bit           src_idle_en;
    bit           sink_idle_en;
    int           sink_hold;
    int           sink_wait;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic void frame_merge(int row_base, int col, logic [7:0] keep,
                                        logic [7:0] val);
        if (col < 0 || col >= ROW_BYTES)
            return;
        frame_mem[row_base + col] = (frame_mem[row_base + col] & keep) | val;
    endfunction

    function automatic blit_result_t blit_predict(blit_req_t r);
        blit_result_t res;
        int           x;
        int           y;
        int           col;
        int           base;
        int           sh;
        logic [7:0]   left_val;
        logic [7:0]   right_val;

        res.read_data = 8'h00;
        if (r.operation == OP_READ)
        begin
            res.status = STATUS_READ;
            if (r.read_address < STORE_BYTES)
                res.read_data = frame_mem[r.read_address];
            return res;
        end

        x = $signed(r.pos_x);
        y = $signed(r.row_y);
        if (y < 0 || y >= SCREEN_H || x <= -4 || x >= SCREEN_W)
        begin
            res.status = STATUS_CLIPPED;
            return res;
        end

        base      = y * ROW_BYTES;
        sh        = (x + 4) & 3;
        col       = ((x + 4) >> 2) - 1;
        left_val  = r.sprite_byte >> (2 * sh);
        right_val = (sh == 0) ? 8'h00 : 8'(r.sprite_byte << (8 - 2 * sh));
        res.status = STATUS_DRAWN;

        if (x < 0)
            frame_merge(base, col + 1, KEEP_RIGHT[sh], right_val);
        else if (x > SCREEN_W - 4)
        begin
            if (sh == 0)
                res.status = STATUS_CLIPPED;
            else
                frame_merge(base, col, KEEP_LEFT[sh], left_val);
        end
        else if (sh == 0)
            frame_merge(base, col, 8'h00, r.sprite_byte);
        else
        begin
            frame_merge(base, col, KEEP_LEFT[sh], left_val);
            frame_merge(base, col + 1, KEEP_RIGHT[sh], right_val);
        end
        return res;
    endfunction

    // response sink: per-request idle draw plus an optional long hold
    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
                sink_wait = sink_idle_en ? $urandom_range(0, 4) : 0;
            if (sink_hold > 0)
            begin
                sink_hold = sink_hold - 1;
                rsp.ready <= 1'b0;
            end
            else if (sink_wait > 0)
            begin
                sink_wait = sink_wait - 1;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        blit_result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected response read_data=%h status=%0d",
                         $time, rsp.read_data, rsp.status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.read_data !== want.read_data)
                begin
                    mismatches++;
                    $display("%0t: read_data expected %h actual %h",
                             $time, want.read_data, rsp.read_data);
                end
                if (rsp.status !== want.status)
                begin
                    mismatches++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp.status);
                end
            end
        end
    end

    task automatic push_request(blit_req_t r);
        int gap;
        gap = src_idle_en ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.operation    <= r.operation;
        req.pos_x        <= r.pos_x;
        req.row_y        <= r.row_y;
        req.sprite_byte  <= r.sprite_byte;
        req.read_address <= r.read_address;
        do
            @(posedge clk);
        while (!req.ready);
        pending_results.push_back(blit_predict(r));
    endtask

    task automatic send_draw(int x, int y, int b);
        blit_req_t r;
        r.operation    = OP_DRAW;
        r.pos_x        = 8'(x);
        r.row_y        = 8'(y);
        r.sprite_byte  = 8'(b);
        r.read_address = ADDR_IN_W'($urandom);
        push_request(r);
    endtask

    task automatic send_read(int addr);
        blit_req_t r;
        r.operation    = OP_READ;
        r.pos_x        = 8'($urandom);
        r.row_y        = 8'($urandom);
        r.sprite_byte  = 8'($urandom);
        r.read_address = ADDR_IN_W'(addr);
        push_request(r);
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic blit_req_t random_request();
        blit_req_t r;
        bit        hot;
        hot            = $urandom_range(0, 1);
        r.operation    = ($urandom_range(0, 2) == 0) ? OP_READ : OP_DRAW;
        r.sprite_byte  = 8'($urandom);
        r.read_address = ADDR_IN_W'($urandom);
        r.pos_x        = 8'(int'($urandom_range(0, SCREEN_W + 7)) - 4);
        r.row_y        = hot ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, SCREEN_H));
        if ($urandom_range(0, 9) == 0)
        begin
            r.pos_x = 8'($urandom);
            r.row_y = 8'($urandom);
        end
        if (r.operation == OP_READ && $urandom_range(0, 9) != 0)
            r.read_address = hot ? ADDR_IN_W'($urandom_range(0, 4 * ROW_BYTES - 1))
                                 : ADDR_IN_W'($urandom_range(0, STORE_BYTES - 1));
        return r;
    endfunction

    task automatic test_reset_contents();
        send_read(0);
        send_read(STORE_BYTES - 1);
        send_read(STORE_BYTES);
        send_read((1 << ADDR_IN_W) - 1);
    endtask

    task automatic test_inner_draws();
        send_draw(0, 0, 8'hff);
        send_draw(5, 0, 8'he4);
        send_draw(10, 0, 8'h1b);
        send_draw(SCREEN_W - 4, 2, 8'ha5);
        send_read(0);
        send_read(1);
        send_read(2);
        send_read(3);
    endtask

    task automatic test_screen_edges();
        send_draw(-1, 1, 8'hff);
        send_draw(-3, 3, 8'h5a);
        send_draw(SCREEN_W - 3, SCREEN_H - 1, 8'hff);
        send_draw(SCREEN_W - 1, SCREEN_H - 2, 8'h96);
        send_read(ROW_BYTES);
        send_read(3 * ROW_BYTES);
        send_read(STORE_BYTES - 1);
        send_read(STORE_BYTES - 1 - ROW_BYTES);
    endtask

    task automatic test_clipping();
        send_draw(-4, 5, 8'hff);
        send_draw(-128, 5, 8'hff);
        send_draw(SCREEN_W, 5, 8'hff);
        send_draw(127, 5, 8'hff);
        send_draw(10, -1, 8'hff);
        send_draw(10, SCREEN_H, 8'hff);
        send_draw(10, 127, 8'hff);
        send_draw(10, -128, 8'hff);
        send_read(5 * ROW_BYTES);
    endtask

    task automatic test_random_traffic(int count, bit src_idle, bit sink_idle);
        src_idle_en  = src_idle;
        sink_idle_en = sink_idle;
        repeat (count)
            push_request(random_request());
    endtask

    task automatic test_output_stall();
        src_idle_en = 1'b0;
        sink_hold   = 300;
        repeat (40)
            push_request(random_request());
    endtask

    task automatic test_drain_pause();
        wait_drained();
        test_random_traffic(60, 1'b1, 1'b1);
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        req.valid        <= 1'b0;
        req.operation    <= OP_DRAW;
        req.pos_x        <= '0;
        req.row_y        <= '0;
        req.sprite_byte  <= '0;
        req.read_address <= '0;
        mismatches   = 0;
        cycle_count  = 0;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        sink_hold    = 0;
        sink_wait    = 0;
        foreach (frame_mem[i])
            frame_mem[i] = 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_contents();
        test_inner_draws();
        test_screen_edges();
        test_clipping();
        test_random_traffic(300, 1'b1, 1'b1);
        test_random_traffic(150, 1'b0, 1'b0);
        test_random_traffic(150, 1'b1, 1'b0);
        test_random_traffic(150, 1'b0, 1'b1);
        test_output_stall();
        test_drain_pause();

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
